// ----- rtl/hsbrgbw_pkg.sv -----
package hsbrgbw_pkg;

	// Input field widths and clamp limits.
	localparam int HUE_W = 9;
	localparam int PCT_W = 7;
	localparam int CHAN_W = 8;

	localparam logic [HUE_W-1:0] HUE_MAX = 9'd360;
	localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;
	localparam logic [5:0] SECTOR_DEG = 6'd60;

	// Sector boundaries in degrees.
	localparam logic [HUE_W-1:0] HUE_60 = 9'd60;
	localparam logic [HUE_W-1:0] HUE_120 = 9'd120;
	localparam logic [HUE_W-1:0] HUE_180 = 9'd180;
	localparam logic [HUE_W-1:0] HUE_240 = 9'd240;
	localparam logic [HUE_W-1:0] HUE_300 = 9'd300;

	// Colour wheel sectors.
	localparam logic [2:0] SECTOR_0 = 3'd0;
	localparam logic [2:0] SECTOR_1 = 3'd1;
	localparam logic [2:0] SECTOR_2 = 3'd2;
	localparam logic [2:0] SECTOR_3 = 3'd3;
	localparam logic [2:0] SECTOR_4 = 3'd4;
	localparam logic [2:0] SECTOR_5 = 3'd5;

	// Denominator of the q and t terms: percent times degrees per sector.
	localparam logic [12:0] DEN_QT = 13'd6000;

	// Numerator widths: b*255 and v*(100-s) stay below 2^15, v*6000 below 2^21.
	localparam int NUM100_W = 15;
	localparam int NUM6000_W = 21;

	// Reciprocals for exact floor division by 100 and by 6000 over those ranges.
	localparam int RECIP100_W = 13;
	localparam logic [RECIP100_W-1:0] RECIP100 = 13'd5243;
	localparam int SHIFT100 = 19;
	localparam int RECIP6000_W = 21;
	localparam logic [RECIP6000_W-1:0] RECIP6000 = 21'd1431656;
	localparam int SHIFT6000 = 33;

	// Number of register stages from an accepted request to its result strobe.
	localparam int PIPE_DEPTH = 5;

endpackage

// ----- rtl/hsbrgbw_recip_div.sv -----
module hsbrgbw_recip_div #(
	parameter int IN_W = 15,
	parameter int OUT_W = 8,
	parameter int RECIP_W = 13,
	parameter logic [RECIP_W-1:0] RECIP = 13'd5243,
	parameter int SHIFT = 19
) (
	input  logic             clk,
	input  logic [IN_W-1:0]  num,
	output logic [OUT_W-1:0] quo
);

	localparam int PROD_W = IN_W + RECIP_W;

	logic [PROD_W-1:0] prod;
	logic [OUT_W-1:0]  quo_q;

	// Floor division by a constant as a multiply by its rounded-up reciprocal.
	assign prod = PROD_W'(num) * PROD_W'(RECIP);

	always_ff @(posedge clk) begin
		quo_q <= prod[SHIFT +: OUT_W];
	end

	assign quo = quo_q;

endmodule

// ----- rtl/hsb_to_rgbw_convert_top.sv -----
// HSB to RGBW colour converter.
// A request is taken at each rising edge where start is high and busy is low;
// busy is never raised, so a new hue/saturation/brightness triple may enter in
// every cycle. Hue clamps to 360 (which wraps to 0), saturation and brightness
// clamp to 100.
// Each request gives one result on red, green, blue and white, marked by done
// for exactly one cycle. Throughput is one result per clock; the result passes
// five register stages: clamp and sector split, scaling of brightness and
// white by 255/100, the v products, the reciprocal divisions for p, q and t,
// and the sector select.
// The receiver cannot hold results off: a result is valid only in the cycle
// that done is high and must be captured there.
// Reset clears the valid bits of all stages, so no result appears until new
// requests arrive; data registers are not reset.
module hsb_to_rgbw_convert_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [hsbrgbw_pkg::HUE_W-1:0]   hue,
	input  logic [hsbrgbw_pkg::PCT_W-1:0]   saturation,
	input  logic [hsbrgbw_pkg::PCT_W-1:0]   brightness,
	output logic                            busy,
	output logic                            done,
	output logic [hsbrgbw_pkg::CHAN_W-1:0]  red,
	output logic [hsbrgbw_pkg::CHAN_W-1:0]  green,
	output logic [hsbrgbw_pkg::CHAN_W-1:0]  blue,
	output logic [hsbrgbw_pkg::CHAN_W-1:0]  white
);

	localparam int HW = hsbrgbw_pkg::HUE_W;
	localparam int PW = hsbrgbw_pkg::PCT_W;
	localparam int CW = hsbrgbw_pkg::CHAN_W;
	localparam int N1W = hsbrgbw_pkg::NUM100_W;
	localparam int N6W = hsbrgbw_pkg::NUM6000_W;

	logic accept;

	// Stage one signals.
	logic [HW-1:0]  hue_c;
	logic [PW-1:0]  sat_c;
	logic [PW-1:0]  bri_c;
	logic [2:0]     sector_c;
	logic [HW-1:0]  base_c;
	logic           valid_s1;
	logic [2:0]     sector_s1;
	logic [5:0]     frac_s1;
	logic [PW-1:0]  sat_s1;
	logic [N1W-1:0] bx255_s1;
	logic [N1W-1:0] wx255_s1;

	// Stage two signals.
	logic           valid_s2;
	logic [2:0]     sector_s2;
	logic [CW-1:0]  v_s2;
	logic [CW-1:0]  w_s2;
	logic [12:0]    sf_s2;
	logic [12:0]    sfc_s2;
	logic [PW-1:0]  s100_s2;

	// Stage three signals.
	logic           valid_s3;
	logic [2:0]     sector_s3;
	logic [CW-1:0]  v_s3;
	logic [CW-1:0]  w_s3;
	logic [N1W-1:0] np_s3;
	logic [N6W-1:0] nq_s3;
	logic [N6W-1:0] nt_s3;

	// Stage four signals.
	logic           valid_s4;
	logic [2:0]     sector_s4;
	logic [CW-1:0]  v_s4;
	logic [CW-1:0]  w_s4;
	logic [CW-1:0]  p_s4;
	logic [CW-1:0]  q_s4;
	logic [CW-1:0]  t_s4;

	// Stage five signals.
	logic           valid_s5;
	logic [CW-1:0]  red_s5;
	logic [CW-1:0]  green_s5;
	logic [CW-1:0]  blue_s5;
	logic [CW-1:0]  white_s5;
	logic [CW-1:0]  red_c;
	logic [CW-1:0]  green_c;
	logic [CW-1:0]  blue_c;

	assign busy = 1'b0;
	assign accept = start && !busy;

	// Valid bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Clamp the inputs; hue of 360 and above wraps to zero.
	always_comb begin
		hue_c = (hue >= hsbrgbw_pkg::HUE_MAX) ? '0 : hue;
		sat_c = (saturation > hsbrgbw_pkg::PCT_MAX) ? hsbrgbw_pkg::PCT_MAX : saturation;
		bri_c = (brightness > hsbrgbw_pkg::PCT_MAX) ? hsbrgbw_pkg::PCT_MAX : brightness;
	end

	// Split the hue into a sector and an offset within it.
	always_comb begin
		if (hue_c >= hsbrgbw_pkg::HUE_300) begin
			sector_c = hsbrgbw_pkg::SECTOR_5;
			base_c = hsbrgbw_pkg::HUE_300;
		end else if (hue_c >= hsbrgbw_pkg::HUE_240) begin
			sector_c = hsbrgbw_pkg::SECTOR_4;
			base_c = hsbrgbw_pkg::HUE_240;
		end else if (hue_c >= hsbrgbw_pkg::HUE_180) begin
			sector_c = hsbrgbw_pkg::SECTOR_3;
			base_c = hsbrgbw_pkg::HUE_180;
		end else if (hue_c >= hsbrgbw_pkg::HUE_120) begin
			sector_c = hsbrgbw_pkg::SECTOR_2;
			base_c = hsbrgbw_pkg::HUE_120;
		end else if (hue_c >= hsbrgbw_pkg::HUE_60) begin
			sector_c = hsbrgbw_pkg::SECTOR_1;
			base_c = hsbrgbw_pkg::HUE_60;
		end else begin
			sector_c = hsbrgbw_pkg::SECTOR_0;
			base_c = '0;
		end
	end

	// Stage one: sector, offset, and brightness and white scaled by 255.
	always_ff @(posedge clk) begin
		sector_s1 <= sector_c;
		frac_s1 <= 6'(hue_c - base_c);
		sat_s1 <= sat_c;
		bx255_s1 <= {bri_c, 8'b0} - N1W'(bri_c);
		wx255_s1 <= {7'(hsbrgbw_pkg::PCT_MAX - sat_c), 8'b0}
			- N1W'(hsbrgbw_pkg::PCT_MAX - sat_c);
	end

	// Stage two: v and white by division by 100.
	hsbrgbw_recip_div #(
		.IN_W(N1W),
		.OUT_W(CW),
		.RECIP_W(hsbrgbw_pkg::RECIP100_W),
		.RECIP(hsbrgbw_pkg::RECIP100),
		.SHIFT(hsbrgbw_pkg::SHIFT100)
	) u_div_v (
		.clk(clk),
		.num(bx255_s1),
		.quo(v_s2)
	);

	hsbrgbw_recip_div #(
		.IN_W(N1W),
		.OUT_W(CW),
		.RECIP_W(hsbrgbw_pkg::RECIP100_W),
		.RECIP(hsbrgbw_pkg::RECIP100),
		.SHIFT(hsbrgbw_pkg::SHIFT100)
	) u_div_w (
		.clk(clk),
		.num(wx255_s1),
		.quo(w_s2)
	);

	// Stage two: saturation times the offset and its complement.
	always_ff @(posedge clk) begin
		sector_s2 <= sector_s1;
		s100_s2 <= hsbrgbw_pkg::PCT_MAX - sat_s1;
		sf_s2 <= 13'(sat_s1) * 13'(frac_s1);
		sfc_s2 <= 13'(sat_s1) * 13'(hsbrgbw_pkg::SECTOR_DEG - frac_s1);
	end

	// Stage three: numerators of p, q and t.
	always_ff @(posedge clk) begin
		sector_s3 <= sector_s2;
		v_s3 <= v_s2;
		w_s3 <= w_s2;
		np_s3 <= N1W'(v_s2) * N1W'(s100_s2);
		nq_s3 <= N6W'(v_s2) * N6W'(hsbrgbw_pkg::DEN_QT - sf_s2);
		nt_s3 <= N6W'(v_s2) * N6W'(hsbrgbw_pkg::DEN_QT - sfc_s2);
	end

	// Stage four: p by 100, q and t by 6000.
	hsbrgbw_recip_div #(
		.IN_W(N1W),
		.OUT_W(CW),
		.RECIP_W(hsbrgbw_pkg::RECIP100_W),
		.RECIP(hsbrgbw_pkg::RECIP100),
		.SHIFT(hsbrgbw_pkg::SHIFT100)
	) u_div_p (
		.clk(clk),
		.num(np_s3),
		.quo(p_s4)
	);

	hsbrgbw_recip_div #(
		.IN_W(N6W),
		.OUT_W(CW),
		.RECIP_W(hsbrgbw_pkg::RECIP6000_W),
		.RECIP(hsbrgbw_pkg::RECIP6000),
		.SHIFT(hsbrgbw_pkg::SHIFT6000)
	) u_div_q (
		.clk(clk),
		.num(nq_s3),
		.quo(q_s4)
	);

	hsbrgbw_recip_div #(
		.IN_W(N6W),
		.OUT_W(CW),
		.RECIP_W(hsbrgbw_pkg::RECIP6000_W),
		.RECIP(hsbrgbw_pkg::RECIP6000),
		.SHIFT(hsbrgbw_pkg::SHIFT6000)
	) u_div_t (
		.clk(clk),
		.num(nt_s3),
		.quo(t_s4)
	);

	always_ff @(posedge clk) begin
		sector_s4 <= sector_s3;
		v_s4 <= v_s3;
		w_s4 <= w_s3;
	end

	// Pick the channels for the sector. With zero saturation p, q and t all
	// equal v, and with zero brightness v, p, q and t are zero, so no special case.
	always_comb begin
		case (sector_s4)
			hsbrgbw_pkg::SECTOR_0: begin
				red_c = v_s4;
				green_c = t_s4;
				blue_c = p_s4;
			end
			hsbrgbw_pkg::SECTOR_1: begin
				red_c = q_s4;
				green_c = v_s4;
				blue_c = p_s4;
			end
			hsbrgbw_pkg::SECTOR_2: begin
				red_c = p_s4;
				green_c = v_s4;
				blue_c = t_s4;
			end
			hsbrgbw_pkg::SECTOR_3: begin
				red_c = p_s4;
				green_c = q_s4;
				blue_c = v_s4;
			end
			hsbrgbw_pkg::SECTOR_4: begin
				red_c = t_s4;
				green_c = p_s4;
				blue_c = v_s4;
			end
			default: begin
				red_c = v_s4;
				green_c = p_s4;
				blue_c = q_s4;
			end
		endcase
	end

	// Stage five: output registers.
	always_ff @(posedge clk) begin
		red_s5 <= red_c;
		green_s5 <= green_c;
		blue_s5 <= blue_c;
		white_s5 <= w_s4;
	end

	assign done = valid_s5;
	assign red = red_s5;
	assign green = green_s5;
	assign blue = blue_s5;
	assign white = white_s5;

`ifndef SYNTHESIS
	// A request that enters the pipeline comes out four stages later.
	a_valid_flow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ##4 done)
		else $error("request lost in the pipeline");

	// No valid bit enters stage two that was not in stage one.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $past(valid_s1))
		else $error("valid bit appeared without a request");

	// Full white means zero saturation, which must give a grey.
	a_grey: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (white == 8'hFF)) |-> ((red == green) && (green == blue)))
		else $error("zero saturation did not give a grey");
`endif

endmodule

// ----- tb/tb_hsb_to_rgbw_convert_top.sv -----
module tb_hsb_to_rgbw_convert_top;

	localparam int HW = hsbrgbw_pkg::HUE_W;
	localparam int PW = hsbrgbw_pkg::PCT_W;
	localparam int CW = hsbrgbw_pkg::CHAN_W;

	// Model limits held as plain integers so the predictor works in 32 bits.
	localparam int unsigned HUE_LIM = 32'(hsbrgbw_pkg::HUE_MAX);
	localparam int unsigned PCT_LIM = 32'(hsbrgbw_pkg::PCT_MAX);
	localparam int unsigned SECT_DEG = 32'(hsbrgbw_pkg::SECTOR_DEG);
	localparam int unsigned DEN = 32'(hsbrgbw_pkg::DEN_QT);

	localparam int unsigned FULL_SCALE = 255;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RANDOM_REQUESTS = 1050;
	localparam int N_DIRECTED = 25;

	typedef struct packed {
		logic [CW-1:0] red;
		logic [CW-1:0] green;
		logic [CW-1:0] blue;
		logic [CW-1:0] white;
	} rgbw_t;

	// One row of the directed table; the colour is used only where typed is set.
	typedef struct packed {
		logic [HW-1:0] hue;
		logic [PW-1:0] sat;
		logic [PW-1:0] bri;
		logic          typed;
		rgbw_t         colour;
	} colour_row_t;

	localparam colour_row_t DIRECTED_ROWS [N_DIRECTED] = '{
		// Zero brightness gives black whatever the saturation.
		'{9'd0,   7'd100, 7'd0,   1'b1, '{8'd0,   8'd0,   8'd0,   8'd0}},
		'{9'd0,   7'd0,   7'd0,   1'b1, '{8'd0,   8'd0,   8'd0,   8'd255}},
		// Zero saturation gives full grey and full white.
		'{9'd0,   7'd0,   7'd100, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd255}},
		// All fields at their maximum: hue clamps to 360 and wraps to red.
		'{9'd511, 7'd127, 7'd127, 1'b1, '{8'd255, 8'd0,   8'd0,   8'd0}},
		'{9'd360, 7'd100, 7'd100, 1'b1, '{8'd255, 8'd0,   8'd0,   8'd0}},
		'{9'd120, 7'd100, 7'd100, 1'b1, '{8'd0,   8'd255, 8'd0,   8'd0}},
		'{9'd240, 7'd100, 7'd100, 1'b1, '{8'd0,   8'd0,   8'd255, 8'd0}},
		'{9'd200, 7'd127, 7'd0,   1'b1, '{8'd0,   8'd0,   8'd0,   8'd0}},
		'{9'd100, 7'd0,   7'd127, 1'b1, '{8'd255, 8'd255, 8'd255, 8'd255}},
		'{9'd0,   7'd50,  7'd100, 1'b1, '{8'd255, 8'd127, 8'd127, 8'd127}},
		// The middle of every sector, and values near the sector edges.
		'{9'd30,  7'd100, 7'd100, 1'b0, '0},
		'{9'd90,  7'd100, 7'd100, 1'b0, '0},
		'{9'd150, 7'd100, 7'd100, 1'b0, '0},
		'{9'd210, 7'd100, 7'd100, 1'b0, '0},
		'{9'd270, 7'd100, 7'd100, 1'b0, '0},
		'{9'd330, 7'd100, 7'd100, 1'b0, '0},
		'{9'd59,  7'd73,  7'd88,  1'b0, '0},
		'{9'd60,  7'd1,   7'd1,   1'b0, '0},
		'{9'd359, 7'd99,  7'd99,  1'b0, '0},
		'{9'd361, 7'd100, 7'd100, 1'b0, '0},
		'{9'd1,   7'd100, 7'd1,   1'b0, '0},
		'{9'd299, 7'd37,  7'd64,  1'b0, '0},
		'{9'd181, 7'd127, 7'd55,  1'b0, '0},
		'{9'd300, 7'd100, 7'd50,  1'b0, '0},
		'{9'd480, 7'd20,  7'd127, 1'b0, '0}
	};

	logic          clk;
	logic          arst_n;
	logic          start;
	logic [HW-1:0] hue;
	logic [PW-1:0] saturation;
	logic [PW-1:0] brightness;
	logic          busy;
	logic          done;
	logic [CW-1:0] red;
	logic [CW-1:0] green;
	logic [CW-1:0] blue;
	logic [CW-1:0] white;

	rgbw_t       pending_colours [$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;

	hsb_to_rgbw_convert_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.busy       (busy),
		.done       (done),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.white      (white)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Colour that the converter should give for one request.
	function automatic rgbw_t predict_rgbw(input logic [HW-1:0] hue_in,
			input logic [PW-1:0] sat_in, input logic [PW-1:0] bri_in);
		int unsigned deg;
		int unsigned sat;
		int unsigned bri;
		int unsigned val;
		int unsigned frac;
		int unsigned p_term;
		int unsigned q_term;
		int unsigned t_term;
		logic [2:0]  sect;
		rgbw_t       colour;
		deg = 32'(hue_in);
		sat = 32'(sat_in);
		bri = 32'(bri_in);
		if (deg > HUE_LIM)
			deg = HUE_LIM;
		if (sat > PCT_LIM)
			sat = PCT_LIM;
		if (bri > PCT_LIM)
			bri = PCT_LIM;
		if (deg == HUE_LIM)
			deg = 0;
		val = bri * FULL_SCALE / PCT_LIM;
		colour.white = CW'((PCT_LIM - sat) * FULL_SCALE / PCT_LIM);
		if (bri == 0) begin
			colour.red = '0;
			colour.green = '0;
			colour.blue = '0;
		end else if (sat == 0) begin
			colour.red = CW'(val);
			colour.green = CW'(val);
			colour.blue = CW'(val);
		end else begin
			sect = 3'(deg / SECT_DEG);
			frac = deg % SECT_DEG;
			p_term = val * (PCT_LIM - sat) / PCT_LIM;
			q_term = val * (DEN - sat * frac) / DEN;
			t_term = val * (DEN - sat * (SECT_DEG - frac)) / DEN;
			case (sect)
				hsbrgbw_pkg::SECTOR_0: begin
					colour.red = CW'(val);
					colour.green = CW'(t_term);
					colour.blue = CW'(p_term);
				end
				hsbrgbw_pkg::SECTOR_1: begin
					colour.red = CW'(q_term);
					colour.green = CW'(val);
					colour.blue = CW'(p_term);
				end
				hsbrgbw_pkg::SECTOR_2: begin
					colour.red = CW'(p_term);
					colour.green = CW'(val);
					colour.blue = CW'(t_term);
				end
				hsbrgbw_pkg::SECTOR_3: begin
					colour.red = CW'(p_term);
					colour.green = CW'(q_term);
					colour.blue = CW'(val);
				end
				hsbrgbw_pkg::SECTOR_4: begin
					colour.red = CW'(t_term);
					colour.green = CW'(p_term);
					colour.blue = CW'(val);
				end
				default: begin
					colour.red = CW'(val);
					colour.green = CW'(p_term);
					colour.blue = CW'(q_term);
				end
			endcase
		end
		return colour;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatch_count++;
	endtask

	task automatic check_channel(input string chan, input logic [CW-1:0] got,
			input logic [CW-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d, expected %0d", chan, got, want));
	endtask

	// Mostly short gaps, a few long ones, none at all in a quiet stretch.
	function automatic int unsigned pick_gap(input bit quiet);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 55)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 24);
	endfunction

	// Hue mostly in range, with sector edges and clamped values mixed in.
	function automatic logic [HW-1:0] pick_hue();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 80)
			return HW'($urandom_range(0, HUE_LIM));
		else if (roll < 90)
			return HW'($urandom_range(0, 6) * SECT_DEG);
		else
			return HW'($urandom_range(HUE_LIM + 1, (1 << HW) - 1));
	endfunction

	function automatic logic [PW-1:0] pick_percent();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 75)
			return PW'($urandom_range(0, PCT_LIM));
		else if (roll < 88)
			return $urandom_range(0, 1) ? hsbrgbw_pkg::PCT_MAX : '0;
		else
			return PW'($urandom_range(PCT_LIM + 1, (1 << PW) - 1));
	endfunction

	// Present one request, wait until it is taken, record its expected colour.
	// Start is lowered only when a gap follows, so back-to-back requests keep it high.
	task automatic send_request(input logic [HW-1:0] h, input logic [PW-1:0] s,
			input logic [PW-1:0] b, input logic typed, input rgbw_t typed_colour,
			input int unsigned gap);
		hue <= h;
		saturation <= s;
		brightness <= b;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (typed)
			pending_colours.push_back(typed_colour);
		else
			pending_colours.push_back(predict_rgbw(h, s, b));
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold requests back until every outstanding colour has come out.
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending_colours.size() != 0)
			@(posedge clk);
	endtask

	// Stimulus: reset, the directed table, then random requests.
	initial begin : p_stimulus
		bit quiet;
		arst_n <= 1'b0;
		start <= 1'b0;
		hue <= '0;
		saturation <= '0;
		brightness <= '0;
		quiet = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_request(DIRECTED_ROWS[i].hue, DIRECTED_ROWS[i].sat, DIRECTED_ROWS[i].bri,
				DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].colour, pick_gap(1'b0));
		wait_drained();

		for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 64 == 0)
				quiet = ($urandom_range(0, 99) < 30);
			if (n % 300 == 299)
				wait_drained();
			send_request(pick_hue(), pick_percent(), pick_percent(), 1'b0, '0,
				pick_gap(quiet));
		end

		wait_drained();
		repeat (hsbrgbw_pkg::PIPE_DEPTH + 4) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Compare each result with the oldest outstanding request.
	always @(posedge clk) begin : p_check
		rgbw_t want;
		if (arst_n && done) begin
			if (pending_colours.size() == 0) begin
				report_mismatch($sformatf("result %0d/%0d/%0d/%0d with no request pending",
					red, green, blue, white));
			end else begin
				want = pending_colours.pop_front();
				check_channel("red", red, want.red);
				check_channel("green", green, want.green);
				check_channel("blue", blue, want.blue);
				check_channel("white", white, want.white);
			end
		end
	end

	// Watchdog against a hung handshake or missing results.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

endmodule
